// File: design/ray_sphere_intersect_macros.svh
// ----------------------------------------------------------------------------
// ray_sphere_intersect_macros.svh
// Assertion macros used by rsi_checker.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// same-cycle implication, sampled on clk, idle in reset
`define RSI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ray_sphere_intersect: assertion failed");

// next-cycle implication
`define RSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ray_sphere_intersect: assertion failed");

`endif

// File: design/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Field widths and constants for the ray / sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int POS_W = 32;
    localparam int DIR_W = 18;
    localparam int RAD_W = 31;
    localparam int OC_W  = POS_W + 1;

    localparam logic [RAD_W-1:0] MAX_DIST = {RAD_W{1'b1}};
    localparam logic signed [POS_W-1:0] MAX_POS = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] MIN_POS = {1'b1, {(POS_W-1){1'b0}}};

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [DIR_W-1:0] dir_t;
    typedef logic [RAD_W-1:0]        rad_t;

endpackage

// File: design/rsi_front.sv
// ----------------------------------------------------------------------------
// rsi_front
// Five stages: oc, products, b and |oc|^2, b^2, discriminant.
// ----------------------------------------------------------------------------
module rsi_front #(
    parameter int FRAC_BITS = 16,
    parameter int B_W       = 37,
    parameter int DP_W      = 75,
    parameter int D_W       = 76
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  rsi_pkg::pos_t        org_in [3],
    input  rsi_pkg::dir_t        dir_in [3],
    input  rsi_pkg::pos_t        ctr_in [3],
    input  rsi_pkg::rad_t        rad_in,
    output logic                 v_out,
    output rsi_pkg::pos_t        org_out [3],
    output rsi_pkg::dir_t        dir_out [3],
    output logic signed [B_W-1:0] b_out,
    output logic [D_W-1:0]       disc_out,
    output logic                 miss_out
);

    localparam int OC_W  = rsi_pkg::OC_W;
    localparam int PR_W  = rsi_pkg::DIR_W + OC_W;
    localparam int B2_W  = PR_W + 2;
    localparam int SQ_W  = 2 * OC_W;
    localparam int NEG_W = 2 * OC_W;
    localparam int RSQ_W = 2 * rsi_pkg::RAD_W;
    localparam int BSQ_W = 2 * B_W;

    logic [4:0] v_reg;

    rsi_pkg::pos_t org1_reg [3], org2_reg [3], org3_reg [3], org4_reg [3], org5_reg [3];
    rsi_pkg::dir_t dir1_reg [3], dir2_reg [3], dir3_reg [3], dir4_reg [3], dir5_reg [3];
    rsi_pkg::rad_t rad1_reg;

    logic signed [OC_W-1:0]  oc_reg [3];
    logic signed [PR_W-1:0]  pr_reg [3];
    logic signed [SQ_W-1:0]  ocsq_reg [3];
    logic [RSQ_W-1:0]        rsq2_reg, rsq3_reg, rsq4_reg;
    logic signed [B_W-1:0]   b3_reg, b4_reg, b5_reg;
    logic [NEG_W-1:0]        neg3_reg, neg4_reg;
    logic [BSQ_W-1:0]        bsq_reg;
    logic [D_W-1:0]          disc_reg;
    logic                    miss_reg;

    logic signed [B2_W-1:0]  b2_next;
    logic signed [SQ_W+1:0]  neg_next;
    logic [B_W-1:0]          bmag_next;
    logic [DP_W-1:0]         pos_next;
    logic [DP_W:0]           diff_next;

    always_comb
    begin
        b2_next = B2_W'(pr_reg[0]) + B2_W'(pr_reg[1]) + B2_W'(pr_reg[2]);
        neg_next = (SQ_W+2)'(ocsq_reg[0]) + (SQ_W+2)'(ocsq_reg[1])
                 + (SQ_W+2)'(ocsq_reg[2]);
        bmag_next = b3_reg[B_W-1] ? B_W'(-b3_reg) : B_W'(b3_reg);
        pos_next = DP_W'(bsq_reg) + DP_W'(rsq4_reg);
        diff_next = {1'b0, pos_next} - (DP_W+1)'(neg4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                oc_reg[i]   <= OC_W'(org_in[i]) - OC_W'(ctr_in[i]);
                org1_reg[i] <= org_in[i];
                dir1_reg[i] <= dir_in[i];
                pr_reg[i]   <= PR_W'(dir1_reg[i]) * PR_W'(oc_reg[i]);
                ocsq_reg[i] <= SQ_W'(oc_reg[i]) * SQ_W'(oc_reg[i]);
                org2_reg[i] <= org1_reg[i];
                dir2_reg[i] <= dir1_reg[i];
                org3_reg[i] <= org2_reg[i];
                dir3_reg[i] <= dir2_reg[i];
                org4_reg[i] <= org3_reg[i];
                dir4_reg[i] <= dir3_reg[i];
                org5_reg[i] <= org4_reg[i];
                dir5_reg[i] <= dir4_reg[i];
            end
            rad1_reg <= rad_in;
            rsq2_reg <= RSQ_W'(rad1_reg) * RSQ_W'(rad1_reg);
            rsq3_reg <= rsq2_reg;
            b3_reg   <= b2_next[B2_W-1:FRAC_BITS];
            neg3_reg <= neg_next[NEG_W-1:0];
            rsq4_reg <= rsq3_reg;
            b4_reg   <= b3_reg;
            neg4_reg <= neg3_reg;
            bsq_reg  <= BSQ_W'(bmag_next) * BSQ_W'(bmag_next);
            b5_reg   <= b4_reg;
            disc_reg <= D_W'(diff_next[DP_W-1:0]);
            miss_reg <= diff_next[DP_W];
        end
    end

    assign v_out    = v_reg[4];
    assign org_out  = org5_reg;
    assign dir_out  = dir5_reg;
    assign b_out    = b5_reg;
    assign disc_out = disc_reg;
    assign miss_out = miss_reg;

endmodule

// File: design/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rsi_sqrt #(
    parameter int S_W = 38
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [2*S_W-1:0] rad_in,
    output logic             v_out,
    output logic [S_W-1:0]   root_out
);

    localparam int RW = S_W + 3;

    logic [S_W-1:0]   v_reg;
    logic [RW-1:0]    rem_reg  [S_W];
    logic [S_W-1:0]   root_reg [S_W];
    logic [2*S_W-1:0] dsh_reg  [S_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[S_W-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < S_W; k++)
    begin : g_stage
        logic [RW-1:0]    rem_prev;
        logic [S_W-1:0]   root_prev;
        logic [2*S_W-1:0] d_prev;
        logic [RW-1:0]    cand;
        logic [RW-1:0]    trial;

        if (k == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign d_prev    = rad_in;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign d_prev    = dsh_reg[k-1];
        end

        always_comb
        begin
            cand  = {rem_prev[RW-3:0], d_prev[2*S_W-1 -: 2]};
            trial = {1'b0, root_prev, 2'b01};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dsh_reg[k] <= {d_prev[2*S_W-3:0], 2'b00};
                if (cand >= trial)
                begin
                    rem_reg[k]  <= cand - trial;
                    root_reg[k] <= {root_prev[S_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= cand;
                    root_reg[k] <= {root_prev[S_W-2:0], 1'b0};
                end
            end
        end
    end

    assign v_out    = v_reg[S_W-1];
    assign root_out = root_reg[S_W-1];

endmodule

// File: design/rsi_back.sv
// ----------------------------------------------------------------------------
// rsi_back
// Root choice, hit point products, saturation and output register.
// ----------------------------------------------------------------------------
module rsi_back #(
    parameter int FRAC_BITS = 16,
    parameter int B_W       = 37,
    parameter int S_W       = 38
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [S_W-1:0]        root_in,
    input  logic signed [B_W-1:0] b_in,
    input  logic                  miss_in,
    input  rsi_pkg::pos_t         org_in [3],
    input  rsi_pkg::dir_t         dir_in [3],
    output logic                  out_valid,
    output logic                  hit,
    output rsi_pkg::rad_t         distance,
    output rsi_pkg::pos_t         point [3]
);

    localparam int E_W   = ((B_W > S_W) ? B_W : S_W) + 2;
    localparam int P_W   = rsi_pkg::DIR_W + E_W;
    localparam int Q_W   = P_W - FRAC_BITS;
    localparam int SUM_W = ((Q_W > rsi_pkg::POS_W) ? Q_W : rsi_pkg::POS_W) + 1;
    localparam int R_W   = rsi_pkg::RAD_W;

    logic [1:0]             v_reg;
    logic                   vo_reg;
    logic signed [E_W-1:0]  d_reg;
    logic                   hita_reg, hitb_reg, hit_reg;
    rsi_pkg::pos_t          orga_reg [3], orgb_reg [3], pt_reg [3];
    rsi_pkg::dir_t          dira_reg [3];
    logic signed [P_W-1:0]  pd_reg [3];
    rsi_pkg::rad_t          dist_b_reg, dist_reg;

    logic signed [E_W-1:0]  nb_next, near_next, far_next;
    logic signed [SUM_W-1:0] sum_next [3];
    rsi_pkg::pos_t          sat_next [3];

    always_comb
    begin
        nb_next   = -E_W'(b_in);
        near_next = nb_next - E_W'(root_in);
        far_next  = nb_next + E_W'(root_in);
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = SUM_W'(orgb_reg[i])
                        + SUM_W'($signed(pd_reg[i][P_W-1:FRAC_BITS]));
            if (sum_next[i][SUM_W-1:rsi_pkg::POS_W-1] == '0
                || sum_next[i][SUM_W-1:rsi_pkg::POS_W-1] == '1)
                sat_next[i] = sum_next[i][rsi_pkg::POS_W-1:0];
            else if (sum_next[i][SUM_W-1])
                sat_next[i] = rsi_pkg::MIN_POS;
            else
                sat_next[i] = rsi_pkg::MAX_POS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[0], in_valid};
            vo_reg <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= near_next[E_W-1] ? far_next : near_next;
            hita_reg <= !miss_in && !far_next[E_W-1];
            orga_reg <= org_in;
            dira_reg <= dir_in;

            for (int i = 0; i < 3; i++)
            begin
                pd_reg[i] <= P_W'(dira_reg[i]) * P_W'(d_reg);
            end
            orgb_reg <= orga_reg;
            hitb_reg <= hita_reg;
            if (d_reg[E_W-1:R_W] != '0)
                dist_b_reg <= rsi_pkg::MAX_DIST;
            else
                dist_b_reg <= d_reg[R_W-1:0];

            hit_reg <= hitb_reg;
            for (int i = 0; i < 3; i++)
            begin
                pt_reg[i] <= hitb_reg ? sat_next[i] : rsi_pkg::MAX_POS;
            end
            dist_reg <= hitb_reg ? dist_b_reg : rsi_pkg::MAX_DIST;
        end
    end

    assign out_valid = vo_reg;
    assign hit       = hit_reg;
    assign distance  = dist_reg;
    assign point     = pt_reg;

endmodule

// File: design/ray_sphere_intersect.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Fixed-point ray / sphere intersection, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | signals                         | role
//  in      | in_valid, in_stall, ray+sphere  | one ray item per cycle, unless stalled
//  out     | out_valid, out_stall, result    | hit, distance, point
//
//  One item per cycle while the output is not stalled. The square root
//  resolves one root bit per stage (S_W = 38 at FRAC_BITS 16).
//  Reset clears all valid bits; no clearing pass.
//  A stall on the output freezes the whole pipe; in_stall follows it while
//  the output register holds an item.
// ----------------------------------------------------------------------------
module ray_sphere_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  rsi_pkg::pos_t origin_x,
    input  rsi_pkg::pos_t origin_y,
    input  rsi_pkg::pos_t origin_z,
    input  rsi_pkg::dir_t dir_x,
    input  rsi_pkg::dir_t dir_y,
    input  rsi_pkg::dir_t dir_z,
    input  rsi_pkg::pos_t center_x,
    input  rsi_pkg::pos_t center_y,
    input  rsi_pkg::pos_t center_z,
    input  rsi_pkg::rad_t radius,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          hit,
    output rsi_pkg::rad_t distance,
    output rsi_pkg::pos_t point_x,
    output rsi_pkg::pos_t point_y,
    output rsi_pkg::pos_t point_z
);

    localparam int B_W   = rsi_pkg::DIR_W + rsi_pkg::OC_W + 2 - FRAC_BITS;
    localparam int BSQ_W = 2 * B_W;
    localparam int DP_W  = ((BSQ_W > 2 * rsi_pkg::OC_W) ? BSQ_W : 2 * rsi_pkg::OC_W) + 1;
    localparam int S_W   = (DP_W + 1) / 2;
    localparam int D_W   = 2 * S_W;

    logic en;

    rsi_pkg::pos_t org_in [3], ctr_in [3], org_f [3], pt [3];
    rsi_pkg::dir_t dir_in [3], dir_f [3];
    logic                  v_f, v_s, miss_f;
    logic signed [B_W-1:0] b_f;
    logic [D_W-1:0]        disc_f;
    logic [S_W-1:0]        root_s;

    logic signed [B_W-1:0] b_dl_reg    [S_W];
    logic                  miss_dl_reg [S_W];
    rsi_pkg::pos_t         org_dl_reg  [S_W][3];
    rsi_pkg::dir_t         dir_dl_reg  [S_W][3];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    assign org_in = '{origin_x, origin_y, origin_z};
    assign dir_in = '{dir_x, dir_y, dir_z};
    assign ctr_in = '{center_x, center_y, center_z};

    rsi_front #(
        .FRAC_BITS (FRAC_BITS),
        .B_W       (B_W),
        .DP_W      (DP_W),
        .D_W       (D_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .org_in   (org_in),
        .dir_in   (dir_in),
        .ctr_in   (ctr_in),
        .rad_in   (radius),
        .v_out    (v_f),
        .org_out  (org_f),
        .dir_out  (dir_f),
        .b_out    (b_f),
        .disc_out (disc_f),
        .miss_out (miss_f)
    );

    rsi_sqrt #(
        .S_W (S_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v_f),
        .rad_in   (disc_f),
        .v_out    (v_s),
        .root_out (root_s)
    );

    // side data alongside the root stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_dl_reg[0]    <= b_f;
            miss_dl_reg[0] <= miss_f;
            org_dl_reg[0]  <= org_f;
            dir_dl_reg[0]  <= dir_f;
            for (int k = 1; k < S_W; k++)
            begin
                b_dl_reg[k]    <= b_dl_reg[k-1];
                miss_dl_reg[k] <= miss_dl_reg[k-1];
                org_dl_reg[k]  <= org_dl_reg[k-1];
                dir_dl_reg[k]  <= dir_dl_reg[k-1];
            end
        end
    end

    rsi_back #(
        .FRAC_BITS (FRAC_BITS),
        .B_W       (B_W),
        .S_W       (S_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_s),
        .root_in   (root_s),
        .b_in      (b_dl_reg[S_W-1]),
        .miss_in   (miss_dl_reg[S_W-1]),
        .org_in    (org_dl_reg[S_W-1]),
        .dir_in    (dir_dl_reg[S_W-1]),
        .out_valid (out_valid),
        .hit       (hit),
        .distance  (distance),
        .point     (pt)
    );

    assign point_x = pt[0];
    assign point_y = pt[1];
    assign point_z = pt[2];

endmodule

// File: design/rsi_checker.sv
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks on the intersection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_sphere_intersect_macros.svh"

module rsi_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input logic          hit,
    input rsi_pkg::rad_t distance,
    input rsi_pkg::pos_t point_x,
    input rsi_pkg::pos_t point_y,
    input rsi_pkg::pos_t point_z
);

    `RSI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(distance))
    `RSI_ASSERT_NOW(a_in_stall_src, in_stall, out_valid && out_stall)
    `RSI_ASSERT_NOW(a_miss_fill, out_valid && !hit, distance == rsi_pkg::MAX_DIST && point_x == rsi_pkg::MAX_POS && point_y == rsi_pkg::MAX_POS && point_z == rsi_pkg::MAX_POS)

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);

// File: dv/ray_sphere_intersect_checker.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_checker
// Watches both channels of the ray / sphere block, works out the expected
// hit, distance and point of every accepted ray and compares them in order.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_checker
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_stall,
    input  pos_t  origin_x,
    input  pos_t  origin_y,
    input  pos_t  origin_z,
    input  dir_t  dir_x,
    input  dir_t  dir_y,
    input  dir_t  dir_z,
    input  pos_t  center_x,
    input  pos_t  center_y,
    input  pos_t  center_z,
    input  rad_t  radius,
    input  logic  out_valid,
    input  logic  out_stall,
    input  logic  hit,
    input  rad_t  distance,
    input  pos_t  point_x,
    input  pos_t  point_y,
    input  pos_t  point_z,
    output int    fail_count,
    output int    pending
);

    typedef struct packed {
        logic hit;
        rad_t distance;
        pos_t px;
        pos_t py;
        pos_t pz;
    } hit_result_t;

    hit_result_t hits_due[$];

    assign pending = hits_due.size();

    function automatic logic signed [127:0] floor_frac(input logic signed [127:0] v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic pos_t clamp_pos(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return MAX_POS;
        if (v < -128'sd2147483648)
            return MIN_POS;
        return v[31:0];
    endfunction

    function automatic logic [63:0] isqrt(input logic [127:0] d);
        logic [63:0] s;
        logic [63:0] c;
        s = '0;
        for (int k = 39; k >= 0; k--)
        begin
            c = s | (64'd1 << k);
            if ({64'd0, c} * {64'd0, c} <= d)
                s = c;
        end
        return s;
    endfunction

    function automatic hit_result_t trace_ray(input pos_t o[3], input dir_t dr[3],
                                              input pos_t ctr[3], input rad_t r);
        logic signed [127:0] oc[3];
        logic signed [127:0] b2, b, s, d, pos_sum, neg_sum;
        hit_result_t res;
        res = '{1'b0, MAX_DIST, MAX_POS, MAX_POS, MAX_POS};
        b2 = 0;
        neg_sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            oc[i] = 128'(o[i]) - 128'(ctr[i]);
            b2 += 128'(dr[i]) * oc[i];
            neg_sum += oc[i] * oc[i];
        end
        b = floor_frac(b2);
        pos_sum = b * b + 128'(r) * 128'(r);
        if (pos_sum < neg_sum)
            return res;
        s = 128'(isqrt(pos_sum - neg_sum));
        d = -b - s;
        if (d < 0)
        begin
            d = -b + s;
            if (d < 0)
                return res;
        end
        res.hit = 1'b1;
        res.distance = (d > 128'sd2147483647) ? MAX_DIST : d[30:0];
        res.px = clamp_pos(128'(o[0]) + floor_frac(128'(dr[0]) * d));
        res.py = clamp_pos(128'(o[1]) + floor_frac(128'(dr[1]) * d));
        res.pz = clamp_pos(128'(o[2]) + floor_frac(128'(dr[2]) * d));
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hit_result_t exp_r;
        hit_result_t got;
        if (!rst_n)
        begin
            fail_count <= 0;
            hits_due.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                hits_due.push_back(trace_ray('{origin_x, origin_y, origin_z},
                    '{dir_x, dir_y, dir_z}, '{center_x, center_y, center_z}, radius));
            if (out_valid && !out_stall)
            begin
                got = '{hit, distance, point_x, point_y, point_z};
                if (hits_due.size() == 0)
                begin
                    $display("%0t: result with no ray pending: %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = hits_due.pop_front();
                    if (got != exp_r)
                    begin
                        $display("%0t: hit exp %0d got %0d, dist exp %h got %h", $time,
                                 exp_r.hit, got.hit, exp_r.distance, got.distance);
                        $display("%0t: point exp %h %h %h got %h %h %h", $time,
                                 exp_r.px, exp_r.py, exp_r.pz, got.px, got.py, got.pz);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: dv/ray_sphere_intersect_tb.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_tb
// Drives directed and random rays into the intersection pipeline with random
// gaps and output stalls, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_tb;
    import rsi_pkg::*;

    localparam int ONE = 1 << 16;
    localparam int RANDOM_RAYS = 1800;
    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    pos_t origin_x = '0, origin_y = '0, origin_z = '0;
    dir_t dir_x = '0, dir_y = '0, dir_z = '0;
    pos_t center_x = '0, center_y = '0, center_z = '0;
    rad_t radius = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    rad_t distance;
    pos_t point_x, point_y, point_z;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   calm = 1'b0;
    bit   hold_off = 1'b0;

    always #4 clk = ~clk;

    ray_sphere_intersect u_top (.*);

    ray_sphere_intersect_checker u_checker (.*);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && idle_cycles > WATCHDOG)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 9);
    end

    function automatic dir_t rand_dir();
        case ($urandom_range(3))
            0: return dir_t'($urandom);
            1: return $urandom_range(1) ? dir_t'(ONE) : dir_t'(-ONE);
            default: return dir_t'(int'($urandom_range(2 * ONE)) - ONE);
        endcase
    endfunction

    function automatic pos_t rand_pos(input bit narrow);
        if (narrow)
            return pos_t'(int'($urandom_range(64 * ONE)) - 32 * ONE);
        return pos_t'($urandom);
    endfunction

    // leaves in_valid high after the item is taken; stop_rays, or the next
    // call when it puts in a gap, drops it in a later time step
    task automatic send_ray(input pos_t o[3], input dir_t dr[3], input pos_t c[3],
                            input rad_t r);
        while (!calm && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        {origin_x, origin_y, origin_z} = {o[0], o[1], o[2]};
        {dir_x, dir_y, dir_z} = {dr[0], dr[1], dr[2]};
        {center_x, center_y, center_z} = {c[0], c[1], c[2]};
        radius = r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic stop_rays();
        in_valid <= 1'b0;
    endtask

    task automatic send_random(input int n);
        pos_t o[3], c[3];
        dir_t dr[3];
        rad_t r;
        bit narrow;
        for (int k = 0; k < n; k++)
        begin
            narrow = ($urandom_range(9) < 8);
            for (int i = 0; i < 3; i++)
            begin
                o[i] = rand_pos(narrow);
                dr[i] = rand_dir();
                c[i] = $urandom_range(3) == 0 ? o[i] + pos_t'($urandom_range(8 * ONE))
                                              : rand_pos(narrow);
            end
            r = narrow ? rad_t'($urandom_range(40 * ONE)) : rad_t'($urandom);
            send_ray(o, dr, c, r);
        end
    endtask

    initial
    begin
        pos_t o[3], c[3];
        dir_t dr[3];
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // hit ahead, origin inside, sphere behind, miss, zero radius
        send_ray('{0, 0, 0}, '{ONE, 0, 0}, '{10 * ONE, 0, 0}, 2 * ONE);
        send_ray('{0, 0, 0}, '{0, ONE, 0}, '{0, 0, 0}, 3 * ONE);
        send_ray('{0, 0, 0}, '{0, 0, ONE}, '{0, 0, -10 * ONE}, ONE);
        send_ray('{0, 0, 0}, '{ONE, 0, 0}, '{10 * ONE, 5 * ONE, 0}, ONE);
        send_ray('{0, 0, 0}, '{ONE, 0, 0}, '{10 * ONE, 0, 0}, 0);
        // tangent, negative directions, non-unit and extreme direction patterns
        send_ray('{0, ONE, 0}, '{ONE, 0, 0}, '{5 * ONE, 0, 0}, ONE);
        send_ray('{0, 0, 0}, '{-ONE, 0, 0}, '{-7 * ONE, 0, 0}, ONE);
        send_ray('{0, 0, 0}, '{131071, -131072, 65535}, '{ONE, ONE, ONE}, 9 * ONE);
        send_ray('{0, 0, 0}, '{-1, 1, 0}, '{3 * ONE, 0, 0}, 5 * ONE);
        // far hit saturation and extreme positions
        send_ray('{MIN_POS, 0, 0}, '{ONE, 0, 0}, '{MAX_POS, 0, 0}, 1);
        send_ray('{MAX_POS, MAX_POS, MAX_POS}, '{ONE, ONE, ONE},
                 '{MAX_POS, MAX_POS, MAX_POS}, MAX_DIST);
        send_ray('{MIN_POS, MIN_POS, MIN_POS}, '{-ONE, -ONE, -ONE},
                 '{MIN_POS, MIN_POS, MIN_POS}, MAX_DIST);
        send_ray('{MIN_POS, MAX_POS, MIN_POS}, '{ONE, -ONE, ONE},
                 '{MAX_POS, MIN_POS, MAX_POS}, MAX_DIST);
        send_ray('{-1, -1, -1}, '{-1, -1, -1}, '{-1, -1, -1}, MAX_DIST);

        calm = 1'b1;
        send_random(200);
        calm = 1'b0;

        // long output hold-off while rays keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(150);
        join

        send_random(RANDOM_RAYS / 2);
        stop_rays();
        while (pending != 0)
            @(negedge clk);
        send_random(RANDOM_RAYS / 2 - 350);
        stop_rays();

        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/rsi_pkg.sv
design/rsi_front.sv
design/rsi_sqrt.sv
design/rsi_back.sv
design/ray_sphere_intersect.sv
design/rsi_checker.sv
dv/ray_sphere_intersect_checker.sv
dv/ray_sphere_intersect_tb.sv
